>>> hw/rtl/svpd_pkg.sv
// Shared types, constants and codes for the solenoid valve PWM driver.
package svpd_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int DELAY_W          = 16;
  localparam int OFF_W            = 5;
  localparam int LEVEL_W          = 7;
  localparam int PROD_W           = OFF_W + DELAY_W;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = DELAY_W;

  localparam logic [LEVEL_W-1:0] FULL_PERCENT    = 7'd100;
  localparam logic [7:0]         RECIP_FIVE      = 8'd205;
  localparam int                 RECIP_SHIFT     = 10;
  localparam logic [DELAY_W-1:0] OPEN_DELAY_RST  = 16'd30;
  localparam logic [DELAY_W-1:0] CLOSE_DELAY_RST = 16'd10;
  localparam logic [DELAY_W-1:0] TIME_MAX        = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERTED    = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_FULL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PEND_NONE    = 2'd0,
    PEND_RELEASE = 2'd1,
    PEND_COIL_ON = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MOD   = 2'd1,
    ST_RATIO = 2'd2
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] percent;
  } in_req_t;

  typedef struct packed {
    logic               coil_drive;
    logic [LEVEL_W-1:0] open_level;
    logic               busy_res;
    logic               rejected;
  } out_res_t;

  typedef struct packed {
    logic [DELAY_W-1:0] open_delay_ms;
    logic [DELAY_W-1:0] close_delay_ms;
    logic               inverted_logic;
  } cfg_regs_t;

endpackage

>>> hw/rtl/svpd_div.sv
// Restoring serial divider: one quotient bit per cycle, 16-bit divisor.
module svpd_div
  import svpd_pkg::*;
#(
  parameter int DIV_W = PROD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [DELAY_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient,
  output logic [DELAY_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   q_r, q_nxt;
  logic [DELAY_W-1:0] rem_r, rem_nxt;
  logic [DELAY_W-1:0] dsor_r, dsor_nxt;
  logic [DELAY_W:0]   shifted;
  logic [DELAY_W+1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    shifted  = {rem_r, q_r[DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dsor_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so its shift fits.
      if (!trial[DELAY_W+1]) begin
        rem_nxt = trial[DELAY_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DELAY_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/svpd_ctrl.sv
// Sequencer and valve state: holds, pending actions, PWM switching, result register.
module svpd_ctrl
  import svpd_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int DIV_W        = PROD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_regs_t          cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_res_t           out_data,
  output logic               div_start,
  output logic [DIV_W-1:0]   div_dividend,
  output logic [DELAY_W-1:0] div_divisor,
  input  logic               div_done,
  input  logic [DIV_W-1:0]   div_quot,
  input  logic [DELAY_W-1:0] div_rem
);

  state_t                  state_r, state_nxt;
  logic [COUNTER_BITS-1:0] ms_r, ms_nxt, ms_inc;
  logic                    coil_r, coil_nxt;
  logic [LEVEL_W-1:0]      level_r, level_nxt;
  logic [DELAY_W-1:0]      on_r, on_nxt;
  logic [OFF_W-1:0]        off_r, off_nxt;
  logic [DELAY_W-1:0]      cyc_r, cyc_nxt;
  logic [DELAY_W-1:0]      hold_r, hold_nxt;
  pend_t                   pend_r, pend_nxt;
  logic [LEVEL_W-1:0]      p_r, p_nxt;
  logic                    outv_r, outv_nxt;
  out_res_t                out_r, out_nxt;

  logic                    accept;
  logic                    finish;
  logic                    rej;
  logic [LEVEL_W-1:0]      pct_clamped;
  logic [LEVEL_W-1:0]      pct_gap;
  logic [14:0]             gap_scaled;
  logic [OFF_W-1:0]        off_calc;
  logic [PROD_W-1:0]       ratio_num;
  logic [DELAY_W-1:0]      close_den;
  logic [DELAY_W-1:0]      on_sat;
  logic [DELAY_W:0]        cyc_sum;

  assign in_stall = !rst_n || !((state_r == ST_IDLE) && (!outv_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign ms_inc   = ms_r + COUNTER_BITS'(1);

  // Off time is (100 - p) / 5, taken as a multiply by 205 and a shift of ten;
  // this is exact for every gap up to 100.
  assign pct_clamped = (in_data.percent > {1'b0, FULL_PERCENT}) ?
                       FULL_PERCENT : in_data.percent[LEVEL_W-1:0];
  assign pct_gap     = FULL_PERCENT - pct_clamped;
  assign gap_scaled  = 15'(pct_gap) * 15'(RECIP_FIVE);
  assign off_calc    = gap_scaled[RECIP_SHIFT +: OFF_W];
  assign ratio_num   = PROD_W'(off_calc) * PROD_W'(cfg.open_delay_ms);
  assign close_den   = (cfg.close_delay_ms == '0) ? DELAY_W'(1) : cfg.close_delay_ms;

  assign on_sat  = (p_r == FULL_PERCENT) ? DELAY_W'(FULL_PERCENT) :
                   (|div_quot[DIV_W-1:DELAY_W]) ? TIME_MAX : div_quot[DELAY_W-1:0];
  assign cyc_sum = {1'b0, on_sat} + (DELAY_W + 1)'(off_r);

  always_comb begin
    state_nxt    = state_r;
    ms_nxt       = ms_r;
    coil_nxt     = coil_r;
    level_nxt    = level_r;
    on_nxt       = on_r;
    off_nxt      = off_r;
    cyc_nxt      = cyc_r;
    hold_nxt     = hold_r;
    pend_nxt     = pend_r;
    p_nxt        = p_r;
    outv_nxt     = outv_r && out_stall;
    out_nxt      = out_r;
    div_start    = 1'b0;
    div_dividend = DIV_W'(ratio_num);
    div_divisor  = close_den;
    finish       = 1'b0;
    rej          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            CMD_TICK: begin
              ms_nxt = ms_inc;
              if (hold_r != '0) begin
                hold_nxt = hold_r - DELAY_W'(1);
                finish   = 1'b1;
                if (hold_r == DELAY_W'(1)) begin
                  pend_nxt = PEND_NONE;
                  if (pend_r == PEND_RELEASE) begin
                    level_nxt = '0;
                    coil_nxt  = 1'b0;
                    hold_nxt  = cfg.close_delay_ms;
                  end else if (pend_r == PEND_COIL_ON) begin
                    coil_nxt = 1'b1;
                  end
                end
              end else if ((level_r != '0) && (cyc_r != '0)) begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(ms_inc);
                div_divisor  = cyc_r;
                state_nxt    = ST_MOD;
              end else begin
                // A zero cycle keeps the coil on while the valve is open.
                if (level_r != '0) begin
                  coil_nxt = 1'b1;
                end
                finish = 1'b1;
              end
            end
            CMD_OPEN: begin
              if (hold_r != '0) begin
                rej    = 1'b1;
                finish = 1'b1;
              end else begin
                p_nxt     = pct_clamped;
                off_nxt   = off_calc;
                div_start = 1'b1;
                state_nxt = ST_RATIO;
              end
            end
            CMD_CLOSE: begin
              finish = 1'b1;
              if (hold_r != '0) begin
                rej = 1'b1;
              end else begin
                level_nxt = '0;
                coil_nxt  = 1'b0;
                hold_nxt  = cfg.close_delay_ms;
                pend_nxt  = PEND_NONE;
              end
            end
            CMD_FULL: begin
              finish = 1'b1;
              if (hold_r != '0) begin
                rej = 1'b1;
              end else begin
                level_nxt = '0;
                hold_nxt  = cfg.close_delay_ms;
                if (cfg.close_delay_ms == '0) begin
                  coil_nxt = 1'b1;
                  pend_nxt = PEND_NONE;
                end else begin
                  coil_nxt = 1'b0;
                  pend_nxt = PEND_COIL_ON;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (div_done) begin
          if (coil_r && (div_rem >= on_r)) begin
            coil_nxt = 1'b0;
          end else if (!coil_r && (div_rem <= on_r)) begin
            coil_nxt = 1'b1;
          end
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RATIO: begin
        if (div_done) begin
          on_nxt  = on_sat;
          cyc_nxt = cyc_sum[DELAY_W] ? TIME_MAX : cyc_sum[DELAY_W-1:0];
          if (level_r == '0) begin
            // Opening from closed: pull-in hold, then release if p is zero.
            coil_nxt  = 1'b1;
            level_nxt = p_r;
            hold_nxt  = cfg.open_delay_ms;
            pend_nxt  = (p_r == '0) ? PEND_RELEASE : PEND_NONE;
            if (cfg.open_delay_ms == '0) begin
              pend_nxt = PEND_NONE;
              if (p_r == '0) begin
                level_nxt = '0;
                coil_nxt  = 1'b0;
                hold_nxt  = cfg.close_delay_ms;
              end
            end
          end else if (p_r == '0) begin
            level_nxt = '0;
            coil_nxt  = 1'b0;
            hold_nxt  = cfg.close_delay_ms;
            pend_nxt  = PEND_NONE;
          end else begin
            level_nxt = p_r;
          end
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      outv_nxt           = 1'b1;
      out_nxt.coil_drive = coil_nxt ^ cfg.inverted_logic;
      out_nxt.open_level = level_nxt;
      out_nxt.busy_res   = (hold_nxt != '0);
      out_nxt.rejected   = rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ms_r    <= '0;
      coil_r  <= 1'b0;
      level_r <= '0;
      on_r    <= '0;
      off_r   <= '0;
      cyc_r   <= '0;
      hold_r  <= '0;
      pend_r  <= PEND_NONE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ms_r    <= ms_nxt;
      coil_r  <= coil_nxt;
      level_r <= level_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      cyc_r   <= cyc_nxt;
      hold_r  <= hold_nxt;
      pend_r  <= pend_nxt;
      outv_r  <= outv_nxt;
    end
    p_r   <= p_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/solenoid_valve_pwm_driver_core.sv
// Top level of the solenoid valve PWM driver: configuration registers and unit wiring.
//
// This block drives a solenoid valve coil with a slow PWM. Each request is
// either a one-millisecond tick or a command (open with a percentage, close,
// or full open), and every request returns exactly one result carrying the
// coil level after polarity, the held opening percentage, a busy flag for a
// running pull-in or release hold, and a flag that says the command was
// ignored because a hold was running. All division goes through one shared
// restoring divider that retires one quotient bit per cycle. A tick that
// must place the millisecond count inside the PWM cycle therefore waits for
// the divider to finish, where the divider width DIV_W is the larger of
// COUNTER_BITS and 21; an open command waits for it too, as it divides the
// off time scaled by the pull-in time by the release time. Ticks during a
// hold, ticks while closed, close, full open and rejected commands finish
// without the divider. The block takes one request at a time and stalls
// its input while in reset and until the current one is finished and the
// result register is free.
// Configuration registers are to be written through the cfg port only while
// the block is idle, which the block itself does not enforce; writes to an
// unused index are ignored. A zero PWM cycle, which arises for openings of
// 96 to 99 percent, keeps the coil on.
module solenoid_valve_pwm_driver_core
  import svpd_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_data
);

  // The divider must hold either the millisecond count or the ratio numerator.
  localparam int DIV_W = (COUNTER_BITS > PROD_W) ? COUNTER_BITS : PROD_W;

  cfg_regs_t          cfg_r, cfg_nxt;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DELAY_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DELAY_W-1:0] div_rem;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN_DELAY:  cfg_nxt.open_delay_ms  = cfg_wdata;
        CFG_CLOSE_DELAY: cfg_nxt.close_delay_ms = cfg_wdata;
        CFG_INVERTED:    cfg_nxt.inverted_logic = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_delay_ms  <= OPEN_DELAY_RST;
      cfg_r.close_delay_ms <= CLOSE_DELAY_RST;
      cfg_r.inverted_logic <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  svpd_ctrl #(
    .COUNTER_BITS (COUNTER_BITS),
    .DIV_W        (DIV_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem)
  );

  svpd_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

endmodule
